[rtl/nnr_pkg.sv]
package nnr_pkg;

	localparam int COORD_W  = 16;
	localparam int PIX_W    = 64;
	localparam int SIZE_W   = 9;
	localparam int DST_W    = 16;
	localparam int STEP_W   = 24;
	localparam int ORIGIN_W = 32;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W   = STEP_W + COORD_W;
	localparam int SUM_W    = PROD_W + 2;

	localparam logic [PIX_W-1:0] NAN_WORD = 64'h7FF8_0000_0000_0000;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_FETCH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_COLS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_ROWS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_COLS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_ROWS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_STEP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COL_ORIGIN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_ORIGIN = 3'd6;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_READ,
		OP_MISS
	} op_t;

	typedef struct packed {
		logic [SIZE_W-1:0]   src_cols;
		logic [SIZE_W-1:0]   src_rows;
		logic [DST_W-1:0]    dst_cols;
		logic [DST_W-1:0]    dst_rows;
		logic [STEP_W-1:0]   scale_step;
		logic [ORIGIN_W-1:0] col_origin;
		logic [ORIGIN_W-1:0] row_origin;
	} cfg_t;

endpackage

[rtl/nnr_req_if.sv]
interface nnr_req_if;
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic [nnr_pkg::COORD_W-1:0]  col;
	logic [nnr_pkg::COORD_W-1:0]  row;
	logic [nnr_pkg::PIX_W-1:0]    pixel_in;

	modport source (output valid, output req_type, output col, output row, output pixel_in,
		input ready);
	modport sink (input valid, input req_type, input col, input row, input pixel_in,
		output ready);
endinterface

[rtl/nnr_rsp_if.sv]
interface nnr_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [nnr_pkg::PIX_W-1:0]  pixel_out;
	logic                       in_range;

	modport source (output valid, output pixel_out, output in_range, input ready);
	modport sink (input valid, input pixel_out, input in_range, output ready);
endinterface

[rtl/nearest_neighbor_resampler_core.sv]
// Nearest-neighbour resampler over a stored source grid.
// req channel: a load request (req_type 0) writes pixel_in into the grid at
// (col, row) and returns nothing; a load outside the active source size is
// dropped. A fetch request (req_type 1) maps the output (col, row) through
// floor(scale_step * coord + origin + 0.5) and returns one response on rsp:
// the stored word with in_range 1, or the NaN pattern with in_range 0.
// Configuration: wr_en, wr_index, wr_data write one register a cycle; write
// only while no request is in flight.
// Throughput: one request per cycle while the queue is not full, set by the grid
// memory, which takes one access (a write or a read) per cycle.
// Fetch path, in order: the multiply (registered on the edge that takes the
// request), classify into the queue, memory read, response buffer.
// Reset: the pipeline, queue and response buffer empty, the registers take
// their defaults; grid contents stay undefined until loaded.
// Stalls: a stalled rsp fills a two-entry response buffer, then the queue
// between front and back, then req.ready falls; loads ahead of the first
// waiting fetch keep draining into the grid while responses wait.
module nearest_neighbor_resampler_core #(
	parameter int COL_BITS  = 8,
	parameter int ROW_BITS  = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	nnr_req_if.sink                           req,
	nnr_rsp_if.source                         rsp,
	input  logic                              wr_en,
	input  logic [nnr_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [nnr_pkg::CFG_W-1:0]         wr_data
);

	localparam int ADDR_W = COL_BITS + ROW_BITS;
	localparam int QW = 2 + ADDR_W + nnr_pkg::PIX_W;
	localparam int Q_DEPTH = 4;

	nnr_pkg::cfg_t cfg_q;

	logic                      q_push, q_full, q_pop, q_valid;
	nnr_pkg::op_t              f_kind;
	logic [ADDR_W-1:0]         f_addr;
	logic [nnr_pkg::PIX_W-1:0] f_data;
	logic [QW-1:0]             q_din, q_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_cols <= 9'd256;
			cfg_q.src_rows <= 9'd256;
			cfg_q.dst_cols <= 16'hFFFF;
			cfg_q.dst_rows <= 16'hFFFF;
			cfg_q.scale_step <= nnr_pkg::STEP_W'(1) << FRAC_BITS;
			cfg_q.col_origin <= '0;
			cfg_q.row_origin <= '0;
		end else if (wr_en) begin
			case (wr_index)
				nnr_pkg::REG_SRC_COLS: cfg_q.src_cols <= wr_data[nnr_pkg::SIZE_W-1:0];
				nnr_pkg::REG_SRC_ROWS: cfg_q.src_rows <= wr_data[nnr_pkg::SIZE_W-1:0];
				nnr_pkg::REG_DST_COLS: cfg_q.dst_cols <= wr_data[nnr_pkg::DST_W-1:0];
				nnr_pkg::REG_DST_ROWS: cfg_q.dst_rows <= wr_data[nnr_pkg::DST_W-1:0];
				nnr_pkg::REG_SCALE_STEP: cfg_q.scale_step <= wr_data[nnr_pkg::STEP_W-1:0];
				nnr_pkg::REG_COL_ORIGIN: cfg_q.col_origin <= wr_data[nnr_pkg::ORIGIN_W-1:0];
				nnr_pkg::REG_ROW_ORIGIN: cfg_q.row_origin <= wr_data[nnr_pkg::ORIGIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	nnr_front #(
		.COL_BITS (COL_BITS),
		.ROW_BITS (ROW_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cfg   (cfg_q),
		.q_full(q_full),
		.q_push(q_push),
		.q_kind(f_kind),
		.q_addr(f_addr),
		.q_data(f_data)
	);

	assign q_din = {f_kind, f_addr, f_data};

	nnr_queue #(
		.WIDTH(QW),
		.DEPTH(Q_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.full  (q_full),
		.pop   (q_pop),
		.valid (q_valid),
		.dout  (q_dout)
	);

	nnr_back #(
		.ADDR_W(ADDR_W)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_kind (nnr_pkg::op_t'(q_dout[QW-1 -: 2])),
		.q_addr (q_dout[nnr_pkg::PIX_W +: ADDR_W]),
		.q_data (q_dout[nnr_pkg::PIX_W-1:0]),
		.q_pop  (q_pop),
		.rsp    (rsp)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("queue push while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue pop while empty");

	a_miss_is_nan: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.in_range) |-> (rsp.pixel_out == nnr_pkg::NAN_WORD))
		else $error("out-of-range response without NaN pattern");

endmodule

[rtl/nnr_ram.sv]
module nnr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/nnr_front.sv]
module nnr_front #(
	parameter int COL_BITS  = 8,
	parameter int ROW_BITS  = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	nnr_req_if.sink                          req,
	input  nnr_pkg::cfg_t                    cfg,
	input  logic                             q_full,
	output logic                             q_push,
	output nnr_pkg::op_t                     q_kind,
	output logic [COL_BITS+ROW_BITS-1:0]     q_addr,
	output logic [nnr_pkg::PIX_W-1:0]        q_data
);

	localparam int SUM_W = nnr_pkg::SUM_W;
	localparam int PROD_W = nnr_pkg::PROD_W;
	localparam int ORIGIN_W = nnr_pkg::ORIGIN_W;
	localparam int COORD_W = nnr_pkg::COORD_W;
	localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

	logic                        v_s1;
	logic                        type_s1;
	logic [COORD_W-1:0]          col_s1;
	logic [COORD_W-1:0]          row_s1;
	logic [nnr_pkg::PIX_W-1:0]   pix_s1;
	logic [PROD_W-1:0]           pc_s1;
	logic [PROD_W-1:0]           pr_s1;
	logic                        dst_ok_s1;

	logic [SUM_W-1:0] sum_c, sum_r, src_c, src_r;
	logic             map_c_ok, map_r_ok, load_ok, drop, adv, in_ready;

	always_comb begin
		sum_c = {2'b00, pc_s1} + {{(SUM_W-ORIGIN_W){cfg.col_origin[ORIGIN_W-1]}}, cfg.col_origin}
			+ HALF;
		sum_r = {2'b00, pr_s1} + {{(SUM_W-ORIGIN_W){cfg.row_origin[ORIGIN_W-1]}}, cfg.row_origin}
			+ HALF;
		src_c = sum_c >> FRAC_BITS;
		src_r = sum_r >> FRAC_BITS;
		map_c_ok = !sum_c[SUM_W-1] && (src_c < SUM_W'(cfg.src_cols))
			&& ((src_c >> COL_BITS) == '0);
		map_r_ok = !sum_r[SUM_W-1] && (src_r < SUM_W'(cfg.src_rows))
			&& ((src_r >> ROW_BITS) == '0);
		load_ok = (col_s1 < COORD_W'(cfg.src_cols)) && ((col_s1 >> COL_BITS) == '0)
			&& (row_s1 < COORD_W'(cfg.src_rows)) && ((row_s1 >> ROW_BITS) == '0);

		drop = (type_s1 == nnr_pkg::REQ_LOAD) && !load_ok;
		adv = v_s1 && (drop || !q_full);
		in_ready = !v_s1 || adv;
		q_push = v_s1 && !drop && !q_full;
		q_data = pix_s1;

		if (type_s1 == nnr_pkg::REQ_LOAD) begin
			q_kind = nnr_pkg::OP_WRITE;
			q_addr = {row_s1[ROW_BITS-1:0], col_s1[COL_BITS-1:0]};
		end else if (dst_ok_s1 && map_c_ok && map_r_ok) begin
			q_kind = nnr_pkg::OP_READ;
			q_addr = {src_r[ROW_BITS-1:0], src_c[COL_BITS-1:0]};
		end else begin
			q_kind = nnr_pkg::OP_MISS;
			q_addr = '0;
		end
	end

	assign req.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && in_ready) begin
			type_s1 <= req.req_type;
			col_s1 <= req.col;
			row_s1 <= req.row;
			pix_s1 <= req.pixel_in;
			pc_s1 <= PROD_W'(cfg.scale_step) * PROD_W'(req.col);
			pr_s1 <= PROD_W'(cfg.scale_step) * PROD_W'(req.row);
			dst_ok_s1 <= (req.col < cfg.dst_cols) && (req.row < cfg.dst_rows);
		end
	end

endmodule

[rtl/nnr_queue.sv]
module nnr_queue #(
	parameter int WIDTH = 84,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign valid = (cnt_q != '0);
	assign dout = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

[rtl/nnr_back.sv]
module nnr_back #(
	parameter int ADDR_W = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  nnr_pkg::op_t               q_kind,
	input  logic [ADDR_W-1:0]          q_addr,
	input  logic [nnr_pkg::PIX_W-1:0]  q_data,
	output logic                       q_pop,
	nnr_rsp_if.source                  rsp
);

	localparam int PIX_W = nnr_pkg::PIX_W;

	logic              v_s1, hit_s1;
	logic [1:0]        cnt_q;
	logic              wr_ptr_q, rd_ptr_q;
	logic [PIX_W:0]    buf_q [2];
	logic [PIX_W-1:0]  rdata, push_word;
	logic              take, room, is_write, is_read;

	always_comb begin
		take = rsp.valid && rsp.ready;
		room = ({1'b0, cnt_q} - {2'b00, take} + {2'b00, v_s1}) < 3'd2;
		is_write = (q_kind == nnr_pkg::OP_WRITE);
		is_read = (q_kind == nnr_pkg::OP_READ);
		q_pop = q_valid && (is_write || room);
		push_word = hit_s1 ? rdata : nnr_pkg::NAN_WORD;
	end

	nnr_ram #(
		.WIDTH(PIX_W),
		.DEPTH(1 << ADDR_W)
	) u_grid (
		.clk  (clk),
		.we   (q_pop && is_write),
		.waddr(q_addr),
		.wdata(q_data),
		.re   (q_pop && is_read),
		.raddr(q_addr),
		.rdata(rdata)
	);

	assign rsp.valid = (cnt_q != 2'd0);
	assign rsp.pixel_out = buf_q[rd_ptr_q][PIX_W-1:0];
	assign rsp.in_range = buf_q[rd_ptr_q][PIX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			cnt_q <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			v_s1 <= q_pop && !is_write;
			if (v_s1) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, v_s1} - {1'b0, take};
		end
	end

	always_ff @(posedge clk) begin
		hit_s1 <= is_read;
		if (v_s1) begin
			buf_q[wr_ptr_q] <= {hit_s1, push_word};
		end
	end

endmodule
